### src/tmcg_pkg.sv
// ----------------------------------------------------------------------------
// tmcg_pkg
// Shared types and constants of the transparent mask copy code generator.
// ----------------------------------------------------------------------------
package tmcg_pkg;

  // Widths of positions, run lengths and window offsets
  localparam int POS_W = 28;
  localparam int LEN_W = 13;
  localparam int OFS_W = 14;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Mask value of a transparent pixel
  localparam logic [7:0] PIX_TRANSPARENT = 8'hFF;

  // x86 opcode bytes
  localparam logic [7:0] OP_ADD_IMM32 = 8'h81;
  localparam logic [7:0] MODRM_ESI    = 8'hC6;
  localparam logic [7:0] MODRM_EDI    = 8'hC7;
  localparam logic [7:0] OP_MOV_ECX   = 8'hB9;
  localparam logic [7:0] OP_MOVSB     = 8'hA4;
  localparam logic [7:0] OP_OPSIZE    = 8'h66;
  localparam logic [7:0] OP_MOVSD     = 8'hA5;
  localparam logic [7:0] OP_REP       = 8'hF3;
  localparam logic [7:0] OP_RET       = 8'hC3;

  // Configuration register indexes
  localparam logic [2:0] REG_WINDOW_X      = 3'd0;
  localparam logic [2:0] REG_WINDOW_Y      = 3'd1;
  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [2:0] REG_MASK_STRIDE   = 3'd4;
  localparam logic [2:0] REG_SOURCE_STRIDE = 3'd5;

  // Configuration register set
  typedef struct packed {
    logic [11:0] window_x;
    logic [11:0] window_y;
    logic [12:0] window_width;
    logic [12:0] window_height;
    logic [13:0] mask_row_stride;
    logic [13:0] source_row_stride;
  } cfg_t;

  // One queued command: a run flush and/or the closing return
  typedef struct packed {
    logic             flush;
    logic             ret;
    logic             src_add;
    logic [POS_W-1:0] src_skip;
    logic             dst_add;
    logic [POS_W-1:0] dst_skip;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // Program phases of the back end, in emission order
  typedef enum logic [2:0] {
    PH_SRC_ADD = 3'd0,
    PH_DST_ADD = 3'd1,
    PH_DWORD   = 3'd2,
    PH_REM     = 3'd3,
    PH_RET     = 3'd4
  } phase_t;

  // Little-endian byte k of a 32-bit immediate
  function automatic logic [7:0] imm_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = v[7:0];
      2'd1:    b = v[15:8];
      2'd2:    b = v[23:16];
      default: b = v[31:24];
    endcase
    return b;
  endfunction

endpackage

### src/tmcg_fifo.sv
// ----------------------------------------------------------------------------
// tmcg_fifo
// Short command queue between the pixel front end and the byte emitter.
// ----------------------------------------------------------------------------
module tmcg_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tmcg_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output tmcg_pkg::cmd_t head,
  output logic           empty
);

  tmcg_pkg::cmd_t mem [tmcg_pkg::Q_DEPTH];

  logic [tmcg_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [tmcg_pkg::Q_AW:0]   count_r;

  assign full  = (count_r == (tmcg_pkg::Q_AW+1)'(tmcg_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### src/tmcg_front.sv
// ----------------------------------------------------------------------------
// tmcg_front
// Pixel front end: counts columns and rows, tracks transparent runs,
// computes source and destination positions and queues flush commands.
// ----------------------------------------------------------------------------
module tmcg_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tmcg_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     pixel,
  input  logic           q_full,
  output logic           q_push,
  output tmcg_pkg::cmd_t q_cmd
);

  localparam int DIM_LIM = (MAX_DIM < 8191) ? MAX_DIM : 8191;
  localparam int CNT_W   = $clog2(DIM_LIM);
  localparam int PW      = tmcg_pkg::POS_W;
  localparam int LW      = tmcg_pkg::LEN_W;
  localparam int OW      = tmcg_pkg::OFS_W;

  // counter and run state
  logic             run_active_r;
  logic [CNT_W-1:0] col_r, row_r;
  logic [LW-1:0]    run_len_r;

  // stage 1: classified pixel
  logic             p1_v_r, p1_start_r, p1_flush_r, p1_ret_r;
  logic [LW-1:0]    p1_len_r;
  logic [CNT_W-1:0] p1_row_r, p1_col_r;
  logic [OW-1:0]    p1_drow_r, p1_dcol_r;

  // stage 2: positions known
  logic             p2_v_r, p2_start_r, p2_flush_r, p2_ret_r;
  logic [LW-1:0]    p2_len_r;
  logic [PW-1:0]    p2_src_r, p2_dst_r;

  // run starts and where esi / edi stand in the program
  logic [PW-1:0] run_src_r, run_dst_r, cur_src_r, cur_dst_r;

  logic [12:0]    w_lim, h_lim;
  logic           adv, acc, trans, row_end, win_end, start, flush;
  logic [CNT_W:0] col_inc, row_inc;
  logic [LW-1:0]  len_new;
  logic [PW-1:0]  start_src, start_dst;
  logic [PW:0]    ds, dd;

  // window size limits: zero acts as one, large values clamp
  always_comb begin
    if (cfg.window_width == '0)                w_lim = 13'd1;
    else if (cfg.window_width > 13'(DIM_LIM))  w_lim = 13'(DIM_LIM);
    else                                       w_lim = cfg.window_width;
    if (cfg.window_height == '0)               h_lim = 13'd1;
    else if (cfg.window_height > 13'(DIM_LIM)) h_lim = 13'(DIM_LIM);
    else                                       h_lim = cfg.window_height;
  end

  // pipeline moves unless a command waits on a full queue
  assign adv      = !(p2_v_r && (p2_flush_r || p2_ret_r) && q_full);
  assign in_ready = adv && rst_n;
  assign acc      = in_valid && adv;

  // classification
  always_comb begin
    trans   = (pixel == tmcg_pkg::PIX_TRANSPARENT);
    col_inc = {1'b0, col_r} + 1'b1;
    row_inc = {1'b0, row_r} + 1'b1;
    row_end = (14'(col_inc) >= {1'b0, w_lim});
    win_end = row_end && (14'(row_inc) >= {1'b0, h_lim});
    start   = trans && !run_active_r;
    flush   = (!trans && run_active_r) || (row_end && trans);
    if (!trans)           len_new = run_len_r;
    else if (run_active_r) len_new = run_len_r + 1'b1;
    else                  len_new = LW'(1);
  end

  // counters and stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      run_len_r    <= '0;
      p1_v_r       <= 1'b0;
    end else begin
      if (adv) p1_v_r <= in_valid;
      if (acc) begin
        run_active_r <= trans && !row_end;
        run_len_r    <= len_new;
        col_r        <= row_end ? '0 : col_inc[CNT_W-1:0];
        if (row_end) row_r <= win_end ? '0 : row_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_start_r <= start;
      p1_flush_r <= flush;
      p1_ret_r   <= win_end;
      p1_len_r   <= len_new;
      p1_row_r   <= row_r;
      p1_col_r   <= col_r;
      p1_drow_r  <= OW'(cfg.window_y) + OW'(row_r);
      p1_dcol_r  <= OW'(cfg.window_x) + OW'(col_r);
    end
  end

  // stage 2: one multiply-add per position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_start_r <= p1_start_r;
      p2_flush_r <= p1_flush_r;
      p2_ret_r   <= p1_ret_r;
      p2_len_r   <= p1_len_r;
      p2_src_r   <= PW'(p1_row_r) * PW'(cfg.source_row_stride) + PW'(p1_col_r);
      p2_dst_r   <= PW'(p1_drow_r) * PW'(cfg.mask_row_stride) + PW'(p1_dcol_r);
    end
  end

  // skips relative to the cursors
  always_comb begin
    start_src = p2_start_r ? p2_src_r : run_src_r;
    start_dst = p2_start_r ? p2_dst_r : run_dst_r;
    ds        = {1'b0, start_src} - {1'b0, cur_src_r};
    dd        = {1'b0, start_dst} - {1'b0, cur_dst_r};

    q_cmd.flush    = p2_flush_r;
    q_cmd.ret      = p2_ret_r;
    q_cmd.src_add  = !ds[PW] && (ds[PW-1:0] != '0);
    q_cmd.src_skip = ds[PW-1:0];
    q_cmd.dst_add  = !dd[PW] && (dd[PW-1:0] != '0);
    q_cmd.dst_skip = dd[PW-1:0];
    q_cmd.len      = p2_len_r;
  end

  assign q_push = p2_v_r && (p2_flush_r || p2_ret_r) && !q_full;

  // run start capture and cursor tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_src_r <= '0;
      run_dst_r <= '0;
      cur_src_r <= '0;
      cur_dst_r <= '0;
    end else if (adv && p2_v_r) begin
      if (p2_start_r) begin
        run_src_r <= p2_src_r;
        run_dst_r <= p2_dst_r;
      end
      if (p2_ret_r) begin
        cur_src_r <= '0;
        cur_dst_r <= '0;
      end else if (p2_flush_r) begin
        cur_src_r <= start_src + PW'(p2_len_r);
        cur_dst_r <= start_dst + PW'(p2_len_r);
      end
    end
  end

endmodule

### src/tmcg_back.sv
// ----------------------------------------------------------------------------
// tmcg_back
// Byte emitter: walks the phases of one queued command and sends one program
// byte per cycle through the output register unless out_ready stalls it.
// ----------------------------------------------------------------------------
module tmcg_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tmcg_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     code_byte,
  output logic           last,
  output logic           program_end
);

  logic [4:0]  done_r;
  logic [2:0]  idx_r;
  logic        out_valid_r, last_r, pend_r;
  logic [7:0]  byte_r;

  tmcg_pkg::phase_t cur_ph;
  logic [4:0]  appl, rem, cur_bit;
  logic [2:0]  plen;
  logic [10:0] blocks;
  logic [1:0]  rsz;
  logic [31:0] imm;
  logic [7:0]  byte_nxt;
  logic        go, phase_last, more;

  assign blocks = head.len[tmcg_pkg::LEN_W-1:2];
  assign rsz    = head.len[1:0];

  // phases this command needs, and those still open
  always_comb begin
    appl[0] = head.flush && head.src_add;
    appl[1] = head.flush && head.dst_add;
    appl[2] = head.flush && (blocks != '0);
    appl[3] = head.flush && (rsz != 2'd0);
    appl[4] = head.ret;
    rem     = appl & ~done_r;
  end

  // earliest open phase
  always_comb begin
    if (rem[0])      cur_ph = tmcg_pkg::PH_SRC_ADD;
    else if (rem[1]) cur_ph = tmcg_pkg::PH_DST_ADD;
    else if (rem[2]) cur_ph = tmcg_pkg::PH_DWORD;
    else if (rem[3]) cur_ph = tmcg_pkg::PH_REM;
    else             cur_ph = tmcg_pkg::PH_RET;
    cur_bit = 5'b00001 << cur_ph;
    more    = |(rem & ~cur_bit);
  end

  // phase length and byte at the current index
  always_comb begin
    imm      = '0;
    byte_nxt = tmcg_pkg::OP_RET;
    plen     = 3'd1;
    unique case (cur_ph)
      tmcg_pkg::PH_SRC_ADD, tmcg_pkg::PH_DST_ADD: begin
        plen = 3'd6;
        imm  = (cur_ph == tmcg_pkg::PH_SRC_ADD) ? 32'(head.src_skip) : 32'(head.dst_skip);
        case (idx_r)
          3'd0:    byte_nxt = tmcg_pkg::OP_ADD_IMM32;
          3'd1:    byte_nxt = (cur_ph == tmcg_pkg::PH_SRC_ADD) ? tmcg_pkg::MODRM_ESI
                                                              : tmcg_pkg::MODRM_EDI;
          default: byte_nxt = tmcg_pkg::imm_byte(imm, 2'(idx_r - 3'd2));
        endcase
      end
      tmcg_pkg::PH_DWORD: begin
        imm = 32'(blocks);
        if (blocks == 11'd1) begin
          plen     = 3'd1;
          byte_nxt = tmcg_pkg::OP_MOVSD;
        end else begin
          plen = 3'd7;
          case (idx_r)
            3'd0:                   byte_nxt = tmcg_pkg::OP_MOV_ECX;
            3'd5:                   byte_nxt = tmcg_pkg::OP_REP;
            3'd6:                   byte_nxt = tmcg_pkg::OP_MOVSD;
            default:                byte_nxt = tmcg_pkg::imm_byte(imm, 2'(idx_r - 3'd1));
          endcase
        end
      end
      tmcg_pkg::PH_REM: begin
        plen = 3'(rsz);
        case (idx_r)
          3'd0:    byte_nxt = (rsz == 2'd1) ? tmcg_pkg::OP_MOVSB : tmcg_pkg::OP_OPSIZE;
          3'd1:    byte_nxt = tmcg_pkg::OP_MOVSD;
          default: byte_nxt = tmcg_pkg::OP_MOVSB;
        endcase
      end
      default: begin
        plen     = 3'd1;
        byte_nxt = tmcg_pkg::OP_RET;
      end
    endcase
  end

  assign phase_last = (idx_r == plen - 3'd1);
  assign go         = !q_empty && (!out_valid_r || out_ready);
  assign q_pop      = go && phase_last && !more;

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        out_valid_r <= 1'b1;
        if (phase_last) begin
          idx_r  <= '0;
          done_r <= more ? (done_r | cur_bit) : '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (go) begin
      byte_r <= byte_nxt;
      last_r <= phase_last && !more;
      pend_r <= (cur_ph == tmcg_pkg::PH_RET);
    end
  end

  assign out_valid   = out_valid_r;
  assign code_byte   = byte_r;
  assign last        = last_r;
  assign program_end = pend_r;

endmodule

### src/transparent_mask_copy_code_generator.sv
// ----------------------------------------------------------------------------
// transparent_mask_copy_code_generator
// Turns a stream of window mask pixels into an x86 copy program.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one mask pixel per transfer (in_tdata[7:0]); the block counts
//           columns and rows of the window itself.
//   out_* : one program byte per transfer (out_tdata[7:0]); out_tlast marks
//           the last byte caused by a pixel, out_tuser the closing ret.
//   cfg_* : register writes (window position, size, strides), ready whenever
//           out of reset; write only while no pixel is in flight.
// Path: a pixel that ends a run passes stage 1, stage 2, the command queue
//   and the output register before its first byte shows. Throughput: one
//   pixel per cycle while the command queue has room; the emitter sends
//   one byte per cycle while out_tready is high, so a pixel that causes k
//   bytes holds the output until all k are sent, and the four-entry queue
//   sets how far pixel input runs ahead of the emitter before in_tready drops.
// Reset: counters, run state, cursors and the queue clear; registers take
//   their reset values (1x1 window at the origin, strides of one).
// Output stall: the output register holds its byte, the queue fills and
//   then in_tready goes low; nothing is lost.
// ----------------------------------------------------------------------------
module transparent_mask_copy_code_generator #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  // program bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] code_byte
  output logic        out_tlast,  // last
  output logic        out_tuser,  // [0] program_end
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  tmcg_pkg::cfg_t cfg_r;
  tmcg_pkg::cmd_t q_cmd, q_head;
  logic           q_push, q_pop, q_full, q_empty;

  assign cfg_ready = rst_n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_x          <= '0;
      cfg_r.window_y          <= '0;
      cfg_r.window_width      <= 13'd1;
      cfg_r.window_height     <= 13'd1;
      cfg_r.mask_row_stride   <= 14'd1;
      cfg_r.source_row_stride <= 14'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tmcg_pkg::REG_WINDOW_X:      cfg_r.window_x          <= cfg_data[11:0];
        tmcg_pkg::REG_WINDOW_Y:      cfg_r.window_y          <= cfg_data[11:0];
        tmcg_pkg::REG_WINDOW_WIDTH:  cfg_r.window_width      <= cfg_data[12:0];
        tmcg_pkg::REG_WINDOW_HEIGHT: cfg_r.window_height     <= cfg_data[12:0];
        tmcg_pkg::REG_MASK_STRIDE:   cfg_r.mask_row_stride   <= cfg_data;
        tmcg_pkg::REG_SOURCE_STRIDE: cfg_r.source_row_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel front end
  tmcg_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .pixel    (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // command queue
  tmcg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // byte emitter
  tmcg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .code_byte   (out_tdata),
    .last        (out_tlast),
    .program_end (out_tuser)
  );

endmodule
